// File: rtl/iemt_pkg.sv
// shared types and constants of the id extent map translator
package iemt_pkg;

  localparam int unsigned IdW = 32;
  localparam logic [IdW-1:0] UNMAPPED_ID = 32'd65534;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_STAGE   = 2'd0,
    OP_OUT2IN  = 2'd1,
    OP_IN2OUT  = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PENDING = 2'd1,
    ST_INVALID = 2'd2,
    ST_DENIED  = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_INITIAL_NS   = 2'd0,
    CFG_CREATOR_PRIV = 2'd1,
    CFG_GROUP_MAP    = 2'd2,
    CFG_SETGROUPS    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]     operation;
    logic [IdW-1:0] lookup_id;
    logic [IdW-1:0] ext_inner_first;
    logic [IdW-1:0] ext_outer_first;
    logic [IdW-1:0] ext_length;
    logic           last_extent;
    logic [IdW-1:0] writer_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] mapped_id;
    logic           found;
  } out_word_t;

  // conditions gathered for a commit decision
  typedef struct packed {
    logic initial_ns;
    logic table_written;
    logic stage_error;
    logic stage_empty;
    logic creator_priv;
    logic single_unit;
    logic owner_match;
    logic group_map;
    logic setgroups_open;
  } commit_req_t;

endpackage

// File: rtl/id_extent_map_translator_core.sv
// top level of the id extent map translator: staging, commit, lookup
//
//  channel   signals                          direction
//  in        in_valid_i in_ready_o in_data_i  word in
//  out       out_valid_o out_ready_i out_data_o word out
//  cfg       cfg_we_i cfg_idx_i cfg_data_i    register write
//
// one word enters an input register, is processed in a single pass and lands
// in the result register; one word per cycle while the result register is not stalled.
// the table and staging registers update as a word leaves the input register,
// so the next word sees the effect of the previous one.
// reset clears counts, flags and valids, clears configuration but sets setgroups; extent storage is not cleared.
// a stalled result holds the input register, which then blocks further words.
module id_extent_map_translator_core
  import iemt_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  // configuration registers
  logic initial_ns_q, creator_priv_q, group_map_q, setgroups_q;

  // pipeline registers
  logic      in_valid_q, out_valid_q;
  in_word_t  in_q;
  out_word_t out_q, out_d;
  logic      advance;

  // extent storage
  logic [MAX_EXTENTS-1:0][IdW-1:0] tbl_inner_q, tbl_outer_q, tbl_len_q;
  logic [MAX_EXTENTS-1:0][IdW-1:0] stg_inner_q, stg_outer_q, stg_len_q;
  logic [MAX_EXTENTS-1:0][IdW-1:0] eff_inner, eff_outer, eff_len;
  logic [CntW-1:0] committed_q, stage_count_q, eff_count;
  logic            stage_error_q, eff_error, room;

  // datapath results
  logic [IdW-1:0] lk_mapped;
  logic           lk_hit;
  commit_req_t    creq;
  status_e        commit_status;
  logic           is_stage, do_commit;

  // handshake
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_ns_q   <= 1'b0;
      creator_priv_q <= 1'b0;
      group_map_q    <= 1'b0;
      setgroups_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INITIAL_NS:   initial_ns_q   <= cfg_data_i[0];
        CFG_CREATOR_PRIV: creator_priv_q <= cfg_data_i[0];
        CFG_GROUP_MAP:    group_map_q    <= cfg_data_i[0];
        CFG_SETGROUPS:    setgroups_q    <= cfg_data_i[0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // staged run including the current extent
  assign room      = stage_count_q < CntW'(MAX_EXTENTS);
  assign eff_count = room ? stage_count_q + 1'b1 : stage_count_q;
  assign eff_error = stage_error_q || (room && (in_q.ext_length == '0));

  always_comb begin
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (room && (stage_count_q == CntW'(i))) begin
        eff_inner[i] = in_q.ext_inner_first;
        eff_outer[i] = in_q.ext_outer_first;
        eff_len[i]   = in_q.ext_length;
      end else begin
        eff_inner[i] = stg_inner_q[i];
        eff_outer[i] = stg_outer_q[i];
        eff_len[i]   = stg_len_q[i];
      end
    end
  end

  // commit decision
  always_comb begin
    creq.initial_ns        = initial_ns_q;
    creq.table_written     = committed_q != '0;
    creq.stage_error       = eff_error;
    creq.stage_empty       = eff_count == '0;
    creq.creator_priv      = creator_priv_q;
    creq.single_unit       = (eff_count == CntW'(1)) && (eff_len[0] == IdW'(1));
    creq.owner_match       = eff_outer[0] == in_q.writer_id;
    creq.group_map         = group_map_q;
    creq.setgroups_open    = setgroups_q;
  end

  iemt_commit_check u_commit (
    .req_i    (creq),
    .status_o (commit_status)
  );

  iemt_lookup #(
    .MaxExtents (MAX_EXTENTS),
    .CntW       (CntW)
  ) u_lookup (
    .tbl_inner_i  (tbl_inner_q),
    .tbl_outer_i  (tbl_outer_q),
    .tbl_len_i    (tbl_len_q),
    .count_i      (committed_q),
    .from_outer_i (in_q.operation == OP_OUT2IN),
    .id_i         (in_q.lookup_id),
    .mapped_o     (lk_mapped),
    .hit_o        (lk_hit)
  );

  assign is_stage  = in_q.operation == OP_STAGE;
  assign do_commit = advance && is_stage && in_q.last_extent && (commit_status == ST_OK);

  // result word
  always_comb begin
    out_d = '0;
    unique case (in_q.operation)
      OP_STAGE: begin
        out_d.status = in_q.last_extent ? commit_status : ST_PENDING;
      end
      OP_OUT2IN, OP_IN2OUT: begin
        out_d.status    = ST_OK;
        out_d.mapped_id = initial_ns_q ? in_q.lookup_id : lk_mapped;
        out_d.found     = initial_ns_q || lk_hit;
      end
      default: begin
        out_d.status = ST_INVALID;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // staging counters and committed count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= '0;
      stage_error_q <= 1'b0;
      committed_q   <= '0;
    end else if (advance && is_stage) begin
      if (in_q.last_extent) begin
        stage_count_q <= '0;
        stage_error_q <= 1'b0;
        if (do_commit) begin
          committed_q <= eff_count;
        end
      end else begin
        stage_count_q <= eff_count;
        stage_error_q <= eff_error;
      end
    end
  end

  // extent storage writes
  always_ff @(posedge clk_i) begin
    if (advance && is_stage && !in_q.last_extent && room) begin
      stg_inner_q[stage_count_q[IdxW-1:0]] <= in_q.ext_inner_first;
      stg_outer_q[stage_count_q[IdxW-1:0]] <= in_q.ext_outer_first;
      stg_len_q[stage_count_q[IdxW-1:0]]   <= in_q.ext_length;
    end
    if (do_commit) begin
      tbl_inner_q <= eff_inner;
      tbl_outer_q <= eff_outer;
      tbl_len_q   <= eff_len;
    end
  end

  // checks on internal state
  a_committed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed_q <= CntW'(MAX_EXTENTS))
    else $error("committed count beyond table depth");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_count_q <= CntW'(MAX_EXTENTS))
    else $error("stage count beyond table depth");

  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (committed_q != '0) |=> $stable(committed_q))
    else $error("committed table changed after first write");

  a_error_needs_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_error_q |-> (stage_count_q != '0))
    else $error("stage error set with nothing staged");

  a_commit_only_unwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_commit |-> (committed_q == '0) && !initial_ns_q)
    else $error("commit while table written or in initial namespace");

endmodule

// File: rtl/iemt_commit_check.sv
// commit permission check for a staged map write
module iemt_commit_check
  import iemt_pkg::*;
(
  input  commit_req_t req_i,
  output status_e     status_o
);

  // checks in priority order
  always_comb begin
    priority if (req_i.initial_ns || req_i.table_written) begin
      status_o = ST_DENIED;
    end else if (req_i.stage_error || req_i.stage_empty) begin
      status_o = ST_INVALID;
    end else if (!req_i.creator_priv &&
                 (!req_i.single_unit || !req_i.owner_match ||
                  (req_i.group_map && req_i.setgroups_open))) begin
      status_o = ST_DENIED;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

// File: rtl/iemt_lookup.sv
// parallel search of the committed extents in one direction
module iemt_lookup
  import iemt_pkg::*;
#(
  parameter int unsigned MaxExtents = 5,
  parameter int unsigned CntW       = 3
) (
  input  logic [MaxExtents-1:0][IdW-1:0] tbl_inner_i,
  input  logic [MaxExtents-1:0][IdW-1:0] tbl_outer_i,
  input  logic [MaxExtents-1:0][IdW-1:0] tbl_len_i,
  input  logic [CntW-1:0]                count_i,
  input  logic                           from_outer_i,
  input  logic [IdW-1:0]                 id_i,
  output logic [IdW-1:0]                 mapped_o,
  output logic                           hit_o
);

  logic [MaxExtents-1:0]          match;
  logic [MaxExtents-1:0][IdW-1:0] dest;
  logic [MaxExtents-1:0][IdW-1:0] offs;

  // per-extent range compare
  always_comb begin
    for (int i = 0; i < MaxExtents; i++) begin
      logic [IdW-1:0] base;
      base     = from_outer_i ? tbl_outer_i[i] : tbl_inner_i[i];
      dest[i]  = from_outer_i ? tbl_inner_i[i] : tbl_outer_i[i];
      offs[i]  = id_i - base;
      match[i] = (CntW'(i) < count_i) && (id_i >= base) && (offs[i] < tbl_len_i[i]);
    end
  end

  // first matching extent wins
  always_comb begin
    hit_o    = 1'b0;
    mapped_o = UNMAPPED_ID;
    for (int i = MaxExtents - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_o    = 1'b1;
        mapped_o = dest[i] + offs[i];
      end
    end
  end

endmodule

// File: bench/tb_id_extent_map_translator_core.sv
// self-checking testbench of the id extent map translator core
module tb_id_extent_map_translator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iemt_pkg::*;

  localparam int unsigned MAX_EXT      = 5;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned REPORT_MAX   = 10;

  // predicted translator state and queue of expected result words
  class id_map_scoreboard;
    logic [IdW-1:0] tab_inner [MAX_EXT];
    logic [IdW-1:0] tab_outer [MAX_EXT];
    logic [IdW-1:0] tab_len   [MAX_EXT];
    logic [IdW-1:0] stg_inner [MAX_EXT];
    logic [IdW-1:0] stg_outer [MAX_EXT];
    logic [IdW-1:0] stg_len   [MAX_EXT];
    int unsigned    table_cnt;
    int unsigned    stg_cnt;
    bit             stg_err;
    bit             init_ns;
    bit             creator_priv;
    bit             group_map;
    bit             setgroups_ok;
    out_word_t      pending_replies [$];
    int unsigned    errors;
    int unsigned    reported;
    int unsigned    checked;
    int unsigned    lookups;
    int unsigned    hits;
    int unsigned    commit_tries;
    int unsigned    commits_ok;

    function new();
      table_cnt    = 0;
      stg_cnt      = 0;
      stg_err      = 1'b0;
      init_ns      = 1'b0;
      creator_priv = 1'b0;
      group_map    = 1'b0;
      setgroups_ok = 1'b1;
      errors       = 0;
      reported     = 0;
      checked      = 0;
      lookups      = 0;
      hits         = 0;
      commit_tries = 0;
      commits_ok   = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, bit v);
      case (idx)
        CFG_INITIAL_NS:   init_ns      = v;
        CFG_CREATOR_PRIV: creator_priv = v;
        CFG_GROUP_MAP:    group_map    = v;
        CFG_SETGROUPS:    setgroups_ok = v;
        default: ;
      endcase
    endfunction

    // commit checks in priority order, table copied only when all pass
    function status_e try_commit(logic [IdW-1:0] writer);
      if (init_ns || table_cnt != 0) return ST_DENIED;
      if (stg_err || stg_cnt == 0) return ST_INVALID;
      if (!creator_priv) begin
        if (stg_cnt != 1 || stg_len[0] != 32'd1) return ST_DENIED;
        if (stg_outer[0] != writer) return ST_DENIED;
        if (group_map && setgroups_ok) return ST_DENIED;
      end
      for (int i = 0; i < stg_cnt; i++) begin
        tab_inner[i] = stg_inner[i];
        tab_outer[i] = stg_outer[i];
        tab_len[i]   = stg_len[i];
      end
      table_cnt = stg_cnt;
      return ST_OK;
    endfunction

    // first matching extent wins, sums wrap at the id width
    function out_word_t translate_id(bit from_outer, logic [IdW-1:0] id);
      out_word_t      r;
      logic [IdW-1:0] base;
      logic [IdW-1:0] dest;
      logic [IdW-1:0] offs;
      r.status    = ST_OK;
      r.mapped_id = UNMAPPED_ID;
      r.found     = 1'b0;
      for (int i = 0; i < table_cnt; i++) begin
        base = from_outer ? tab_outer[i] : tab_inner[i];
        dest = from_outer ? tab_inner[i] : tab_outer[i];
        offs = id - base;
        if (!r.found && id >= base && offs < tab_len[i]) begin
          r.mapped_id = dest + offs;
          r.found     = 1'b1;
        end
      end
      return r;
    endfunction

    function out_word_t predict_reply(in_word_t w);
      out_word_t r;
      r = '0;
      case (op_e'(w.operation))
        OP_STAGE: begin
          // extents past capacity are dropped unchecked
          if (stg_cnt < MAX_EXT) begin
            stg_inner[stg_cnt] = w.ext_inner_first;
            stg_outer[stg_cnt] = w.ext_outer_first;
            stg_len[stg_cnt]   = w.ext_length;
            if (w.ext_length == '0) stg_err = 1'b1;
            stg_cnt++;
          end
          if (w.last_extent) begin
            r.status = try_commit(w.writer_id);
            commit_tries++;
            if (r.status == ST_OK) commits_ok++;
            stg_cnt = 0;
            stg_err = 1'b0;
          end else begin
            r.status = ST_PENDING;
          end
        end
        OP_OUT2IN, OP_IN2OUT: begin
          lookups++;
          if (init_ns) begin
            r.mapped_id = w.lookup_id;
            r.found     = 1'b1;
          end else begin
            r = translate_id(w.operation == OP_OUT2IN, w.lookup_id);
          end
          if (r.found) hits++;
        end
        default: r.status = ST_INVALID;
      endcase
      return r;
    endfunction

    function void accept_request(in_word_t w);
      pending_replies.push_back(predict_reply(w));
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (reported < REPORT_MAX)
          $display("unexpected result word: status %0d id %h found %0b",
                   got.status, got.mapped_id, got.found);
        reported++;
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.status !== want.status || got.mapped_id !== want.mapped_id ||
          got.found !== want.found) begin
        errors++;
        if (reported < REPORT_MAX) begin
          $write("mismatch at result %0d: expected status %0d id %h found %0b, ",
                 checked, want.status, want.mapped_id, want.found);
          $display("got status %0d id %h found %0b",
                   got.status, got.mapped_id, got.found);
        end
        reported++;
      end
    endfunction
  endclass

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_word_t   in_data_i  = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_word_t  out_data_o;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = CFG_INITIAL_NS;
  logic [0:0] cfg_data_i = 1'b0;

  id_map_scoreboard sb = new();

  int unsigned cycle_count    = 0;
  int unsigned words_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;

  id_extent_map_translator_core #(
    .MAX_EXTENTS(MAX_EXT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // result side: check accepted words, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_reply(out_data_o);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run time limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.pending_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // word with every field random
  function automatic in_word_t noise_word();
    in_word_t w;
    w.operation       = 2'($urandom_range(3));
    w.lookup_id       = $urandom;
    w.ext_inner_first = $urandom;
    w.ext_outer_first = $urandom;
    w.ext_length      = $urandom;
    w.last_extent     = 1'($urandom_range(1));
    w.writer_id       = $urandom;
    return w;
  endfunction

  function automatic in_word_t stage_word(logic [IdW-1:0] inner, logic [IdW-1:0] outer,
                                          logic [IdW-1:0] len, bit last,
                                          logic [IdW-1:0] writer);
    in_word_t w;
    w                 = noise_word();
    w.operation       = OP_STAGE;
    w.ext_inner_first = inner;
    w.ext_outer_first = outer;
    w.ext_length      = len;
    w.last_extent     = last;
    w.writer_id       = writer;
    return w;
  endfunction

  function automatic in_word_t lookup_word(op_e op, logic [IdW-1:0] id);
    in_word_t w;
    w           = noise_word();
    w.operation = op;
    w.lookup_id = id;
    return w;
  endfunction

  // ids at and around the edges of committed extents, or anywhere
  function automatic logic [IdW-1:0] pick_lookup_id(bit from_outer);
    int unsigned    k;
    logic [IdW-1:0] base;
    logic [IdW-1:0] len;
    if (sb.table_cnt == 0 || $urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        default: return $urandom;
      endcase
    end
    k    = $urandom_range(sb.table_cnt - 1);
    base = from_outer ? sb.tab_outer[k] : sb.tab_inner[k];
    len  = sb.tab_len[k];
    case ($urandom_range(4))
      0:       return base;
      1:       return base - 1;
      2:       return base + len - 1;
      3:       return base + len;
      default: return base + $urandom_range(63);
    endcase
  endfunction

  function automatic logic [IdW-1:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1, 2, 3: return 32'd1;
      4, 5, 6: return $urandom_range(2, 16);
      default: return $urandom;
    endcase
  endfunction

  // offer one word and wait for its accept
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.accept_request(w);
    words_sent++;
  endtask

  // stop offering and wait until every expected result is in
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(bit init, bit priv, bit grp, bit sg);
    bit       vals [4];
    cfg_reg_e idx;
    vals = '{init, priv, grp, sg};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[i];
      sb.set_reg(idx, vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // one map write: mostly single owner extents, some runs, some without a last mark
  task automatic map_write_burst();
    int unsigned    n;
    logic [IdW-1:0] writer;
    logic [IdW-1:0] outer;
    bit             last;
    n      = ($urandom_range(3) == 0) ? $urandom_range(2, 7) : 1;
    writer = $urandom;
    for (int i = 0; i < n; i++) begin
      outer = $urandom_range(1) ? writer : $urandom;
      last  = (i == n - 1) && ($urandom_range(9) != 0);
      send_word(stage_word($urandom, outer, pick_length(), last, writer));
    end
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned idle_pct,
                              int unsigned stall_pct);
    int unsigned start;
    bit          dir;
    in_word_t    w;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = words_sent;
    while (words_sent - start < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: map_write_burst();
        4, 5, 6, 7, 8: begin
          dir = $urandom_range(1);
          send_word(lookup_word(dir ? OP_OUT2IN : OP_IN2OUT, pick_lookup_id(dir)));
        end
        default: begin
          w = noise_word();
          send_word(w);
        end
      endcase
    end
    drain();
  endtask

  // main sequence
  initial begin
    in_word_t       w;
    logic [IdW-1:0] own;
    own = 32'd1000;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty table lookups, unknown operation, refused commits
    send_word(lookup_word(OP_OUT2IN, '0));
    send_word(lookup_word(OP_IN2OUT, '1));
    w = noise_word();
    w.operation = OP_UNKNOWN;
    send_word(w);
    // zero length is invalid before the ownership rule
    send_word(stage_word(32'd5, own, '0, 1'b1, own));
    // more than one extent without privilege
    send_word(stage_word(32'd0, own, 32'd1, 1'b0, own));
    send_word(stage_word(32'd1, own + 1, 32'd1, 1'b1, own));
    // single extent that is too long
    send_word(stage_word(32'd0, own, 32'd2, 1'b1, own));
    // single extent that maps someone else
    send_word(stage_word(32'd0, own + 1, 32'd1, 1'b1, own));
    // sixth extent over capacity: its zero length is ignored, its last mark ends a run refused without privilege
    for (int i = 0; i < MAX_EXT; i++)
      send_word(stage_word(i, own + i, 32'd1, 1'b0, own));
    send_word(stage_word(32'd9, own, '0, 1'b1, own));
    drain();

    // group map while setgroups is still allowed
    set_config(1'b0, 1'b0, 1'b1, 1'b1);
    send_word(stage_word(32'd0, own, 32'd1, 1'b1, own));
    drain();

    // initial namespace: identity lookups, writes refused even when privileged
    set_config(1'b1, 1'b1, 1'b0, 1'b0);
    send_word(lookup_word(OP_OUT2IN, '1));
    send_word(stage_word(32'd0, own, 32'd1, 1'b1, own));
    drain();

    // random traffic that can never commit, with a long result hold-off
    set_config(1'b1, 1'b1, 1'b0, 1'b0);
    hold_req = 300;
    random_phase(300, 0, 0);
    set_config(1'b0, 1'b0, 1'b1, 1'b1);
    random_phase(150, 59, 0);
    random_phase(150, 59, 0);
    // close any run left open by the random traffic, refused under these settings
    send_word(stage_word(32'd0, own, 32'd1, 1'b1, own));
    drain();

    // the one commit: privileged, full table with overlaps and wrapping ranges
    set_config(1'b0, 1'b1, 1'b1, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(stage_word(32'd0, 32'd100000, 32'd1000, 1'b0, own));
    send_word(stage_word(32'd500, 32'hffff_ff00, 32'h200, 1'b0, own));
    send_word(stage_word(32'hffff_fff0, 32'd200, 32'h20, 1'b0, own));
    send_word(stage_word(32'h1234_5678, 32'hc000_0000, 32'hffff_ffff, 1'b0, own));
    send_word(stage_word(32'd7, 32'd100500, 32'd1, 1'b1, $urandom));
    send_word(lookup_word(OP_OUT2IN, 32'd220));
    send_word(lookup_word(OP_IN2OUT, '1));
    send_word(lookup_word(OP_OUT2IN, 32'd100500));
    send_word(lookup_word(OP_OUT2IN, '1));
    drain();

    // table written: lookups against it, every later commit refused
    set_config(1'b0, 1'b0, 1'b0, 1'b0);
    random_phase(400, 0, 59);
    set_config(1'b0, 1'b1, 1'b1, 1'b0);
    random_phase(300, 19, 19);
    set_config(1'b1, 1'b0, 1'b1, 1'b1);
    random_phase(200, 19, 19);

    repeat (10) @(posedge clk_i);
    if (sb.pending_replies.size() != 0) begin
      sb.errors += sb.pending_replies.size();
      $display("%0d expected results never arrived", sb.pending_replies.size());
    end
    $display("%0d words over nine settings, %0d results checked, %0d of %0d lookups hit",
             words_sent, sb.checked, sb.hits, sb.lookups);
    $display("%0d map commits tried, %0d taken, %0d mismatches, %0d cycles",
             sb.commit_tries, sb.commits_ok, sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/iemt_pkg.sv
rtl/iemt_commit_check.sv
rtl/iemt_lookup.sv
rtl/id_extent_map_translator_core.sv
bench/tb_id_extent_map_translator_core.sv
